[src/idff_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the integer decimal field formatter.
// No dependencies.
package idff_pkg;

  localparam int MAX_FIELD_DEF  = 64;
  localparam int VALUE_BITS_DEF = 64;

  localparam logic [1:0] LM_INT   = 2'd0;
  localparam logic [1:0] LM_SHORT = 2'd1;
  localparam logic [1:0] LM_LONG  = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
    logic [1:0]  length_mode;
    logic        force_plus;
    logic        space_sign;
    logic        left_justify;
    logic        has_precision;
    logic [5:0]  precision;
    logic [6:0]  field_width;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_word_t;

  // field settings handed to the character sequencer
  typedef struct packed {
    logic       neg;
    logic       force_plus;
    logic       space_sign;
    logic       left_justify;
    logic       has_precision;
    logic [5:0] precision;
    logic [6:0] field_width;
  } fmt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } fsm_state_t;

  // decimal digits needed for an unsigned value of vb bits (log10(2) ~ 0.30103)
  function automatic int num_digits(input int vb);
    return (vb * 30103) / 100000 + 1;
  endfunction

endpackage

[src/integer_decimal_field_formatter.sv]
`timescale 1ns / 1ps
// Integer decimal field formatter, printf-style %d / %u. Uses idff_pkg, idff_bcd, idff_emit.
// Each input word is converted by the one-bit-per-cycle BCD shifter, then its characters
// go out one a cycle while out_ready does not stall them. in_ready is low from the
// time a word is taken until the last character of its field has been taken.
// Synchronous active-low reset clears the sequencer; the digit store is not cleared.
module integer_decimal_field_formatter import idff_pkg::*; #(
  parameter int MAX_FIELD  = MAX_FIELD_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int DIGITS = num_digits(VALUE_BITS);
  localparam int NDW    = $clog2(DIGITS + 1);
  localparam int W16    = (VALUE_BITS < 16) ? VALUE_BITS : 16;
  localparam int W32    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam logic [5:0] W16M1 = 6'(W16 - 1);
  localparam logic [5:0] W32M1 = 6'(W32 - 1);
  localparam logic [5:0] W64M1 = 6'(VALUE_BITS - 1);

  fsm_state_t state_r, state_nxt;
  logic       accept, conv_start, emit_start;
  logic       conv_busy, emit_busy;
  fmt_t       fmt_r;

  logic [5:0]            wm1;
  logic                  msb, neg;
  logic [63:0]           cut, mag64;
  logic [VALUE_BITS-1:0] mag;
  logic [NDW-1:0]        nd;
  logic [DIGITS-1:0][3:0] digits;

  // length cut, sign extension and magnitude
  always_comb begin
    case (in_word.length_mode)
      LM_INT:   wm1 = W32M1;
      LM_SHORT: wm1 = W16M1;
      LM_LONG:  wm1 = W64M1;
      default:  wm1 = W64M1;
    endcase
    msb = in_word.value[wm1];
    for (int i = 0; i < 64; i++) begin
      cut[i] = (6'(i) <= wm1 && i < 64) ? in_word.value[i] : (in_word.is_signed & msb);
    end
    neg   = in_word.is_signed & cut[63];
    mag64 = neg ? (64'd0 - cut) : cut;
    mag   = mag64[VALUE_BITS-1:0];
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    conv_start = 1'b0;
    emit_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          conv_start = 1'b1;
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!conv_busy) begin
          emit_start = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fmt_r.neg           <= neg;
      fmt_r.force_plus    <= in_word.force_plus;
      fmt_r.space_sign    <= in_word.space_sign;
      fmt_r.left_justify  <= in_word.left_justify;
      fmt_r.has_precision <= in_word.has_precision;
      fmt_r.precision     <= in_word.precision;
      fmt_r.field_width   <= in_word.field_width;
    end
  end

  idff_bcd #(
    .VALUE_BITS(VALUE_BITS)
  ) u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .mag    (mag),
    .busy   (conv_busy),
    .nd     (nd),
    .digits (digits)
  );

  idff_emit #(
    .MAX_FIELD  (MAX_FIELD),
    .VALUE_BITS (VALUE_BITS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (emit_start),
    .fmt       (fmt_r),
    .nd        (nd),
    .digits    (digits),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

[src/idff_bcd.sv]
`timescale 1ns / 1ps
// Binary to BCD converter: one shift-add-3 step per cycle, taking the magnitude MSB first.
// Tracks the significant digit count as it goes. Uses idff_pkg.
module idff_bcd import idff_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int DIGITS = num_digits(VALUE_BITS),
  localparam int NDW = $clog2(DIGITS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [VALUE_BITS-1:0]        mag,
  output logic                         busy,
  output logic [NDW-1:0]               nd,
  output logic [DIGITS-1:0][3:0]       digits
);

  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int IW = $clog2(DIGITS);

  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0]  mag_r;
  logic [DIGITS-1:0][3:0] bcd_r;
  logic [DIGITS-1:0][3:0] adj;
  logic [4*DIGITS-1:0]    adj_f;
  logic [DIGITS-1:0][3:0] bcd_nxt;
  logic [NDW-1:0]         nd_r, nd_nxt;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    adj_f   = adj;
    bcd_nxt = {adj_f[4*DIGITS-2:0], mag_r[VALUE_BITS-1]};
    nd_nxt  = nd_r;
    if (nd_r < NDW'(DIGITS)) begin
      if (bcd_nxt[nd_r[IW-1:0]] != 4'd0) begin
        nd_nxt = nd_r + NDW'(1);
      end
    end
    cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(VALUE_BITS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
      bcd_r <= '0;
      nd_r  <= '0;
    end else if (cnt_r != '0) begin
      mag_r <= {mag_r[VALUE_BITS-2:0], 1'b0};
      bcd_r <= bcd_nxt;
      nd_r  <= nd_nxt;
    end
  end

  assign busy   = (cnt_r != '0);
  assign nd     = nd_r;
  assign digits = bcd_r;

endmodule

[src/idff_emit.sv]
`timescale 1ns / 1ps
// Character sequencer: lays out padding, sign and digits, one word per cycle while
// out_ready does not stall the registered output stage. Uses idff_pkg.
module idff_emit import idff_pkg::*; #(
  parameter int MAX_FIELD  = MAX_FIELD_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int DIGITS = num_digits(VALUE_BITS),
  localparam int NDW = $clog2(DIGITS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  fmt_t                   fmt,
  input  logic [NDW-1:0]         nd,
  input  logic [DIGITS-1:0][3:0] digits,
  output logic                   busy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_word
);

  localparam int IW = $clog2(DIGITS);
  localparam logic [6:0] MAXF = 7'(MAX_FIELD);

  logic       active_r;
  logic [6:0] pos_r;
  logic       ov_r;
  out_word_t  ow_r;
  logic       left_r, hs_r;
  logic [7:0] sc_r;
  logic [5:0] dl_r;
  logic [6:0] blen_r, pad_r, emit_r;

  logic [5:0] prec_eff, nd6, nd_eff, dl;
  logic       hs;
  logic [7:0] sc;
  logic [6:0] blen, total, emit_cnt, pad;

  logic       in_body, last, step;
  logic [6:0] q, k, idx, pos_inc;
  logic [3:0] dsel;
  logic [7:0] ch;

  // field layout
  always_comb begin
    prec_eff = fmt.has_precision ? fmt.precision : 6'd0;
    nd6      = 6'(nd);
    nd_eff   = (nd6 == 6'd0 && !fmt.has_precision) ? 6'd1 : nd6;
    dl       = (prec_eff > nd_eff) ? prec_eff : nd_eff;
    hs       = fmt.neg | fmt.force_plus | fmt.space_sign;
    sc       = fmt.neg ? CH_MINUS : (fmt.force_plus ? CH_PLUS : CH_SPACE);
    blen     = {1'b0, dl} + {6'd0, hs};
    total    = (fmt.field_width > blen) ? fmt.field_width : blen;
    emit_cnt = (total > MAXF) ? MAXF : total;
    pad      = total - blen;
  end

  // character at pos_r
  always_comb begin
    pos_inc = pos_r + 7'd1;
    last    = (pos_inc == emit_r);
    if (left_r) begin
      in_body = (pos_r < blen_r);
      q       = pos_r;
    end else begin
      in_body = (pos_r >= pad_r);
      q       = in_body ? pos_r - pad_r : 7'd0;
    end
    k    = q - {6'd0, hs_r};
    idx  = {1'b0, dl_r} - 7'd1 - k;
    dsel = digits[idx[IW-1:0]];
    if (!in_body) begin
      ch = CH_SPACE;
    end else if (hs_r && q == 7'd0) begin
      ch = sc_r;
    end else if (idx < 7'(DIGITS)) begin
      ch = CH_ZERO + {4'd0, dsel};
    end else begin
      ch = CH_ZERO;
    end
    step = active_r && (!ov_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
      pos_r    <= '0;
    end else if (start) begin
      active_r <= (emit_cnt != 7'd0);
      pos_r    <= '0;
    end else if (step) begin
      ov_r  <= 1'b1;
      pos_r <= pos_inc;
      if (last) begin
        active_r <= 1'b0;
      end
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      left_r <= fmt.left_justify;
      hs_r   <= hs;
      sc_r   <= sc;
      dl_r   <= dl;
      blen_r <= blen;
      pad_r  <= pad;
      emit_r <= emit_cnt;
    end
    if (step) begin
      ow_r.out_char <= ch;
      ow_r.last     <= last;
    end
  end

  assign busy      = active_r | ov_r;
  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule

[src/idff_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for integer_decimal_field_formatter, bound to the top level.
// Uses idff_pkg.
module idff_checker import idff_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // one item at a time
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while converting");

  a_no_take_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a field is being emitted");

  // nothing follows the last character until a new item has been converted
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_word.last |=> !out_valid)
    else $error("character after end of field");

endmodule

bind integer_decimal_field_formatter idff_checker u_idff_checker (.*);
